FILE: rtl/core/text_condenser_fsm_macros.svh
// ----------------------------------------------------------------------------
// Text condenser assertion macros
// Clocked assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONDENSER_FSM_MACROS_SVH
`define TEXT_CONDENSER_FSM_MACROS_SVH

`ifndef SYNTHESIS
// check prop on every rising clk outside reset
`define TC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// check that cond never holds
`define TC_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define TC_ASSERT(lbl, prop, msg)
`define TC_NEVER(lbl, cond, msg)
`endif

`endif

FILE: rtl/core/tcond_pkg.sv
// ----------------------------------------------------------------------------
// Text condenser package
// Types, character codes and widths shared by the condenser modules.
// ----------------------------------------------------------------------------
package tcond_pkg;

	localparam int BYTE_W         = 8;
	localparam int VALUE_W        = 16;
	localparam int COUNT_BITS_DEF = 16;
	localparam int MAX_RES        = 3;
	localparam int RES_IDX_W      = 2;

	localparam logic [BYTE_W-1:0] CHAR_NUL    = 8'h00;
	localparam logic [BYTE_W-1:0] CHAR_TAB    = 8'h09;
	localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h0A;
	localparam logic [BYTE_W-1:0] CHAR_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CHAR_SPACE  = 8'h20;
	localparam logic [BYTE_W-1:0] CHAR_LPAREN = 8'h28;
	localparam logic [BYTE_W-1:0] CHAR_RPAREN = 8'h29;
	localparam logic [BYTE_W-1:0] COMMENT_RST = 8'h2A;

	typedef enum logic [1:0] {
		MODE_TEXT    = 2'd0,
		MODE_WHITE   = 2'd1,
		MODE_COMMENT = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_LINE  = 2'd1,
		KIND_COUNT = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [VALUE_W-1:0] value;
	} word_t;

	// words caused by one input item, packed from slot 0 up
	typedef struct packed {
		logic [RES_IDX_W-1:0]      cnt;
		word_t [MAX_RES-1:0]       words;
		mode_t                     mode_nxt;
	} step_t;

endpackage

FILE: rtl/core/tcond_rules.sv
// ----------------------------------------------------------------------------
// Text condenser rules
// Mode transitions, word generation and counter updates for one input byte.
// ----------------------------------------------------------------------------
module tcond_rules
	import tcond_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	localparam int CNT_W = (COUNT_BITS < VALUE_W) ? COUNT_BITS : VALUE_W
) (
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              eot,
	input  logic [BYTE_W-1:0] comment_char,
	input  mode_t             mode,
	input  logic [CNT_W-1:0]  out_count,
	input  logic [CNT_W-1:0]  line_count,
	output logic [CNT_W-1:0]  out_count_nxt,
	output logic [CNT_W-1:0]  line_count_nxt,
	output step_t             step
);

	localparam int NCAND = 4;

	logic              is_cmt, is_ws, is_paren, is_lf, is_nul;
	logic              lead_sp, body, trail_sp;
	mode_t             mode_nxt;
	word_t             cand    [NCAND];
	logic [NCAND-1:0]  cand_en;
	logic [1:0]        nbytes;
	logic [CNT_W+1:0]  out_sum;

	assign is_cmt   = (in_byte == comment_char);
	assign is_ws    = ((in_byte >= CHAR_TAB) && (in_byte <= CHAR_CR)) || (in_byte == CHAR_SPACE);
	assign is_paren = (in_byte == CHAR_LPAREN) || (in_byte == CHAR_RPAREN);
	assign is_lf    = (in_byte == CHAR_LF);
	assign is_nul   = (in_byte == CHAR_NUL);

	always_comb begin : next_mode
		mode_nxt = mode;
		if (eot) begin
			mode_nxt = MODE_TEXT;
		end else begin
			case (mode)
				MODE_COMMENT: begin
					if (is_lf) mode_nxt = MODE_WHITE;
				end
				MODE_WHITE: begin
					if (is_cmt) mode_nxt = MODE_COMMENT;
					else if (!is_ws && !is_paren) mode_nxt = MODE_TEXT;
				end
				default: begin
					if (is_cmt) mode_nxt = MODE_COMMENT;
					else if (is_ws || is_paren) mode_nxt = MODE_WHITE;
					else mode_nxt = MODE_TEXT;
				end
			endcase
		end
	end

	always_comb begin : byte_flags
		lead_sp  = 1'b0;
		body     = 1'b0;
		trail_sp = 1'b0;
		if (!eot) begin
			case (mode)
				MODE_COMMENT: begin
				end
				MODE_WHITE: begin
					if (!is_cmt && !is_ws) begin
						if (is_paren) begin
							body     = 1'b1;
							trail_sp = 1'b1;
						end else begin
							body = !is_nul;
						end
					end
				end
				default: begin
					if (is_cmt || is_ws) begin
						lead_sp = 1'b1;
					end else if (is_paren) begin
						lead_sp  = 1'b1;
						body     = 1'b1;
						trail_sp = 1'b1;
					end else begin
						body = !is_nul;
					end
				end
			endcase
		end
	end

	// candidates in order: line record, space, byte, space (eot: NUL, count)
	always_comb begin : candidates
		if (eot) begin
			cand[0] = '{kind: KIND_BYTE,  value: VALUE_W'(CHAR_NUL)};
			cand[1] = '{kind: KIND_COUNT, value: VALUE_W'(line_count)};
			cand[2] = '{kind: KIND_BYTE,  value: VALUE_W'(CHAR_NUL)};
			cand[3] = '{kind: KIND_BYTE,  value: VALUE_W'(CHAR_NUL)};
			cand_en = 4'b0011;
		end else begin
			cand[0] = '{kind: KIND_LINE, value: VALUE_W'(out_count)};
			cand[1] = '{kind: KIND_BYTE, value: VALUE_W'(CHAR_SPACE)};
			cand[2] = '{kind: KIND_BYTE, value: VALUE_W'(in_byte)};
			cand[3] = '{kind: KIND_BYTE, value: VALUE_W'(CHAR_SPACE)};
			cand_en = {trail_sp, body, lead_sp, is_lf};
		end
	end

	// compact enabled candidates into the result slots
	always_comb begin : pack_words
		logic [2:0] n;
		n          = 3'd0;
		step.words = '0;
		for (int i = 0; i < NCAND; i++) begin
			if (cand_en[i]) begin
				if (n < 3'(MAX_RES)) step.words[n[RES_IDX_W-1:0]] = cand[i];
				n = n + 3'd1;
			end
		end
		step.cnt      = n[RES_IDX_W-1:0];
		step.mode_nxt = mode_nxt;
	end

	assign nbytes  = 2'({1'b0, lead_sp} + {1'b0, body} + {1'b0, trail_sp});
	assign out_sum = {2'b00, out_count} + (CNT_W+2)'(nbytes);

	always_comb begin : counters
		if (eot) begin
			out_count_nxt  = '0;
			line_count_nxt = '0;
		end else begin
			// saturate at all ones
			out_count_nxt  = (out_sum[CNT_W+1:CNT_W] != 2'b00) ? '1 : out_sum[CNT_W-1:0];
			line_count_nxt = line_count;
			if (is_lf && (line_count != '1)) line_count_nxt = line_count + 1'b1;
		end
	end

endmodule

FILE: rtl/core/text_condenser_fsm.sv
// The first result word is offered in the cycle after its input word is taken.
// Throughput: one input word per cycle while each causes at most one result word and the receiver takes
//   every word; an input word that causes several words holds the result register until its last word is taken.
// Input words that cause no result leave the result register idle and show nothing.
// Reset (arst_n low): mode to text, both counters to zero, result register empty,
//   comment character to 0x2A.
// ----------------------------------------------------------------------------
// Text condenser top level
// Collapses whitespace, drops comments and NULs, spaces out parentheses and
// reports line ends and the final line count over a streaming interface.
// ----------------------------------------------------------------------------
`include "text_condenser_fsm_macros.svh"

module text_condenser_fsm
	import tcond_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [BYTE_W-1:0]  cfg_wdata,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [BYTE_W-1:0]  s_tdata,   // [7:0] in_byte
	input  logic               s_tlast,   // end_of_text
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [VALUE_W-1:0] m_tdata,   // [15:0] value
	output logic [1:0]         m_tuser,   // [1:0] kind
	output logic               m_tlast    // last
);

	localparam int CNT_W = (COUNT_BITS < VALUE_W) ? COUNT_BITS : VALUE_W;

	logic [BYTE_W-1:0]    comment_q;
	mode_t                mode_q;
	logic [CNT_W-1:0]     out_cnt_q, line_cnt_q;
	logic [CNT_W-1:0]     out_cnt_nxt, line_cnt_nxt;
	step_t                step;

	logic                 vld_q;
	logic [RES_IDX_W-1:0] idx_q, lst_q;
	word_t                words_q [MAX_RES];

	logic                 acc, out_fire, drain_last;

	tcond_rules #(.COUNT_BITS(COUNT_BITS)) u_rules (
		.in_byte        (s_tdata),
		.eot            (s_tlast),
		.comment_char   (comment_q),
		.mode           (mode_q),
		.out_count      (out_cnt_q),
		.line_count     (line_cnt_q),
		.out_count_nxt  (out_cnt_nxt),
		.line_count_nxt (line_cnt_nxt),
		.step           (step)
	);

	assign out_fire   = vld_q && m_tready;
	assign drain_last = out_fire && (idx_q == lst_q);
	assign s_tready   = !vld_q || drain_last;
	assign acc        = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comment_q <= COMMENT_RST;
		end else if (cfg_we) begin
			comment_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_TEXT;
			out_cnt_q  <= '0;
			line_cnt_q <= '0;
		end else if (acc) begin
			mode_q     <= step.mode_nxt;
			out_cnt_q  <= out_cnt_nxt;
			line_cnt_q <= line_cnt_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
			lst_q <= '0;
		end else if (acc) begin
			// load the new bundle; an empty one leaves the register idle
			vld_q <= (step.cnt != '0);
			idx_q <= '0;
			lst_q <= step.cnt - 1'b1;
		end else if (out_fire) begin
			if (idx_q == lst_q) vld_q <= 1'b0;
			else idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			for (int i = 0; i < MAX_RES; i++) words_q[i] <= step.words[i];
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = words_q[idx_q].value;
	assign m_tuser  = words_q[idx_q].kind;
	assign m_tlast  = (idx_q == lst_q);

	`TC_NEVER(a_idx_range, vld_q && ((idx_q > lst_q) || (lst_q > 2'(MAX_RES - 1))), "result index out of range")
	`TC_ASSERT(a_eot_clear, (acc && s_tlast) |=> (mode_q == MODE_TEXT && out_cnt_q == '0 && line_cnt_q == '0), "state not cleared after end of text")
	`TC_ASSERT(a_eot_nul, (acc && s_tlast) |=> (m_tvalid && m_tuser == KIND_BYTE && m_tdata == '0 && !m_tlast), "end of text does not open with terminator")

endmodule

FILE: sim/text_condenser_fsm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text condenser stream checker
// Watches the comment register port and both stream channels. It predicts the
// result words of every accepted input word and compares each result word, in
// order and field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module text_condenser_fsm_checker
	import tcond_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [BYTE_W-1:0]  cfg_wdata,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [BYTE_W-1:0]  s_tdata,   // [7:0] in_byte
	input  logic               s_tlast,   // end_of_text
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [VALUE_W-1:0] m_tdata,   // [15:0] value
	input  logic [1:0]         m_tuser,   // [1:0] kind
	input  logic               m_tlast,   // last
	output int                 mismatches,
	output int                 pending,
	output int                 words_checked
);

	typedef struct packed {
		kind_t              kind;
		logic [VALUE_W-1:0] value;
		logic               last;
	} cond_word_t;

	localparam longint unsigned FULL_RANGE = (64'd1 << COUNT_BITS) - 64'd1;
	localparam logic [VALUE_W-1:0] COUNT_MAX =
		(FULL_RANGE > 64'hFFFF) ? 16'hFFFF : FULL_RANGE[VALUE_W-1:0];

	logic [BYTE_W-1:0]  comment_byte;
	mode_t              cond_mode;
	logic [VALUE_W-1:0] byte_total;
	logic [VALUE_W-1:0] line_total;
	cond_word_t         expected_words[$];
	cond_word_t         burst [MAX_RES];
	int                 burst_len;

	function automatic logic [VALUE_W-1:0] bump(input logic [VALUE_W-1:0] v);
		return (v >= COUNT_MAX) ? COUNT_MAX : v + 1'b1;
	endfunction

	function automatic logic is_blank(input logic [BYTE_W-1:0] c);
		return (c >= CHAR_TAB && c <= CHAR_CR) || c == CHAR_SPACE;
	endfunction

	function automatic logic is_paren(input logic [BYTE_W-1:0] c);
		return c == CHAR_LPAREN || c == CHAR_RPAREN;
	endfunction

	task automatic emit(input kind_t k, input logic [VALUE_W-1:0] v);
		if (burst_len < MAX_RES) begin
			burst[burst_len] = '{kind: k, value: v, last: 1'b0};
			burst_len++;
		end
	endtask

	// an output byte also advances the running offset
	task automatic emit_byte(input logic [BYTE_W-1:0] c);
		emit(KIND_BYTE, {8'h00, c});
		byte_total = bump(byte_total);
	endtask

	task automatic condense(input logic [BYTE_W-1:0] c, input logic eot);
		burst_len = 0;
		if (eot) begin
			// terminator is not counted; state returns to reset, register stays
			emit(KIND_BYTE, '0);
			emit(KIND_COUNT, line_total);
			cond_mode  = MODE_TEXT;
			byte_total = '0;
			line_total = '0;
		end else begin
			if (c == CHAR_LF) begin
				emit(KIND_LINE, byte_total);
				line_total = bump(line_total);
			end
			case (cond_mode)
				MODE_COMMENT: begin
					if (c == CHAR_LF)
						cond_mode = MODE_WHITE;
				end
				MODE_WHITE: begin
					if (c == comment_byte) begin
						cond_mode = MODE_COMMENT;
					end else if (is_paren(c)) begin
						emit_byte(c);
						emit_byte(CHAR_SPACE);
					end else if (!is_blank(c)) begin
						cond_mode = MODE_TEXT;
						if (c != CHAR_NUL)
							emit_byte(c);
					end
				end
				default: begin
					if (c == comment_byte) begin
						cond_mode = MODE_COMMENT;
						emit_byte(CHAR_SPACE);
					end else if (is_blank(c)) begin
						cond_mode = MODE_WHITE;
						emit_byte(CHAR_SPACE);
					end else if (is_paren(c)) begin
						cond_mode = MODE_WHITE;
						emit_byte(CHAR_SPACE);
						emit_byte(c);
						emit_byte(CHAR_SPACE);
					end else begin
						cond_mode = MODE_TEXT;
						if (c != CHAR_NUL)
							emit_byte(c);
					end
				end
			endcase
		end
		if (burst_len > 0)
			burst[burst_len-1].last = 1'b1;
		for (int i = 0; i < burst_len; i++)
			expected_words.push_back(burst[i]);
	endtask

	task automatic check_word();
		cond_word_t want;
		words_checked++;
		if (expected_words.size() == 0) begin
			mismatches++;
			$display("%0t: word with nothing expected: kind %0d value %0h last %0b",
				$time, m_tuser, m_tdata, m_tlast);
		end else begin
			want = expected_words.pop_front();
			if (m_tuser != want.kind) begin
				mismatches++;
				$display("%0t: kind expected %0d actual %0d",
					$time, want.kind, m_tuser);
			end
			if (m_tdata != want.value) begin
				mismatches++;
				$display("%0t: value expected %0h actual %0h",
					$time, want.value, m_tdata);
			end
			if (m_tlast != want.last) begin
				mismatches++;
				$display("%0t: last expected %0b actual %0b",
					$time, want.last, m_tlast);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comment_byte  = COMMENT_RST;
			cond_mode     = MODE_TEXT;
			byte_total    = '0;
			line_total    = '0;
			mismatches    = 0;
			words_checked = 0;
			expected_words.delete();
		end else begin
			if (cfg_we)
				comment_byte = cfg_wdata;
			if (s_tvalid && s_tready)
				condense(s_tdata, s_tlast);
			if (m_tvalid && m_tready)
				check_word();
		end
		pending = expected_words.size();
	end

endmodule

FILE: sim/tb_text_condenser_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text condenser testbench
// Drives text words through the condenser under several comment characters,
// with random gaps on both channels and one long output stall. The checker
// predicts and compares.
// ----------------------------------------------------------------------------
module tb_text_condenser_fsm;
	import tcond_pkg::*;

	localparam int STALL_LIMIT    = 2000;
	localparam int HOLD_CYCLES    = 64;
	localparam int RAND_PER_PHASE = 35;
	localparam int NUM_PHASES     = 9;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [BYTE_W-1:0]  cfg_wdata;
	logic               s_tvalid;
	logic               s_tready;
	logic [BYTE_W-1:0]  s_tdata;
	logic               s_tlast;
	logic               m_tvalid;
	logic               m_tready;
	logic [VALUE_W-1:0] m_tdata;
	logic [1:0]         m_tuser;
	logic               m_tlast;

	int                 mismatches;
	int                 pending;
	int                 words_checked;

	bit                 idle_en;
	bit                 hold_req;
	int                 hold_left;
	int                 rx_wait;
	int                 quiet_cycles;
	int                 items_sent;
	int                 settings_used;
	logic [BYTE_W-1:0]  cur_comment;

	text_condenser_fsm dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	text_condenser_fsm_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tlast       (s_tlast),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast),
		.mismatches    (mismatches),
		.pending       (pending),
		.words_checked (words_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: random wait per word, plus a long hold on request
	initial begin
		m_tready  = 1'b0;
		hold_left = 0;
		rx_wait   = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (rx_wait > 0) begin
				m_tready <= 1'b0;
				rx_wait--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk)
		if (m_tvalid && m_tready)
			rx_wait = idle_en ? $urandom_range(0, 3) : 0;

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_word(input logic [BYTE_W-1:0] b, input logic eot);
		int gap;
		gap = idle_en ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eot;
		do @(posedge clk); while (!(s_tvalid && s_tready));
		@(negedge clk);
		items_sent++;
	endtask

	// drain everything, then give words that cause nothing time to pass
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_comment(input logic [BYTE_W-1:0] v);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		cur_comment = v;
		settings_used++;
	endtask

	// mostly text-like bytes with the interesting codes weighted up
	task automatic send_random();
		int r;
		logic [BYTE_W-1:0] b;
		logic eot;
		r   = $urandom_range(0, 99);
		b   = 8'($urandom_range(0, 255));
		eot = 1'b0;
		if (r < 3)
			eot = 1'b1;
		else if (r < 13)
			b = CHAR_LF;
		else if (r < 20)
			b = cur_comment;
		else if (r < 35) begin
			r = $urandom_range(0, 5);
			b = (r == 5) ? CHAR_SPACE : CHAR_TAB + r[7:0];
		end else if (r < 45)
			b = $urandom_range(0, 1) ? CHAR_LPAREN : CHAR_RPAREN;
		else if (r < 50)
			b = CHAR_NUL;
		else if (r < 80)
			b = 8'("a" + $urandom_range(0, 25));
		send_word(b, eot);
	endtask

	initial begin
		logic [BYTE_W-1:0] setting;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tlast       = 1'b0;
		idle_en       = 1'b1;
		hold_req      = 1'b0;
		quiet_cycles  = 0;
		items_sent    = 0;
		settings_used = 1;
		cur_comment   = COMMENT_RST;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// every rule of each mode under the reset comment character
		send_word("a", 1'b0);
		send_word(CHAR_SPACE, 1'b0);
		send_word(CHAR_TAB, 1'b0);
		send_word(CHAR_LPAREN, 1'b0);
		send_word("b", 1'b0);
		send_word(CHAR_RPAREN, 1'b0);
		send_word(CHAR_NUL, 1'b0);
		send_word(CHAR_NUL, 1'b0);
		send_word(CHAR_LF, 1'b0);
		send_word(COMMENT_RST, 1'b0);
		send_word(CHAR_LPAREN, 1'b0);
		send_word(CHAR_LF, 1'b0);
		send_word("c", 1'b0);
		send_word(COMMENT_RST, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(CHAR_LF, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(CHAR_CR, 1'b0);
		send_word(8'h0B, 1'b0);
		send_word(8'h7F, 1'b0);
		send_word(8'h08, 1'b0);
		send_word(8'h0E, 1'b0);
		send_word(8'hFF, 1'b1);
		send_word(8'h00, 1'b1);

		// comment character at the extremes and on space, parens and newline
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0:       setting = 8'h00;
				1:       setting = 8'hFF;
				2:       setting = CHAR_SPACE;
				3:       setting = CHAR_LPAREN;
				4:       setting = CHAR_RPAREN;
				5:       setting = CHAR_LF;
				8:       setting = COMMENT_RST;
				default: setting = 8'($urandom_range(0, 255));
			endcase
			write_comment(setting);
			for (int i = 0; i < RAND_PER_PHASE; i++) begin
				if (i % 12 == 0)
					idle_en = ($urandom_range(0, 3) != 0);
				// stall the output while input keeps coming so the block backs up
				if (p == 2 && i == 10)
					hold_req = 1'b1;
				send_random();
			end
		end

		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);

		$display("Covered %0d input words under %0d comment characters",
			items_sent, settings_used);
		$display("and one long output stall; %0d result words compared.", words_checked);
		if (mismatches == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
